>>> hw/rtl/evtc_pkg.sv
`default_nettype none

package evtc_pkg;

	localparam int LITERAL_MAX_DEF = 48;

	// Token stream byte codes.
	localparam logic [7:0] TOK_LIT  = 8'd0;
	localparam logic [7:0] TOK_ARG  = 8'd1;
	localparam logic [7:0] TOK_END  = 8'd2;
	localparam logic [7:0] TOK_TIME = 8'd3;

	// Template characters with special meaning.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int DEC_LIMIT = 255;

	// Final status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_END_DOLLAR = 3'd1;
	localparam logic [2:0] ST_END_DEC   = 3'd2;
	localparam logic [2:0] ST_DEC_RANGE = 3'd3;
	localparam logic [2:0] ST_BAD_ESC   = 3'd4;

	localparam logic signed [4:0] ARG_NONE = -5'sd1;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_DOLLAR,
		PH_A1,
		PH_A2,
		PH_A3,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_TIME,
		TK_ARG
	} tok_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_HDR,
		SQ_DATA,
		SQ_TOK0,
		SQ_TOK1,
		SQ_END
	} seq_t;

	// Everything the sequencer must do for one accepted item.
	typedef struct packed {
		logic              store;
		logic [7:0]        store_byte;
		logic              flush;
		tok_t              tok;
		logic [7:0]        arg_byte;
		logic              fin;
		logic [7:0]        fin_byte;
		logic [2:0]        fin_status;
		logic signed [4:0] fin_high;
	} act_t;

	// Where the sequencer goes once any literal run is out.
	function automatic seq_t seq_follow(tok_t tok, logic fin);
		seq_t s;
		if (tok != TK_NONE) begin
			s = SQ_TOK0;
		end else if (fin) begin
			s = SQ_END;
		end else begin
			s = SQ_IDLE;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/evtc_ram.sv
`default_nettype none

module evtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/evtc_parser.sv
`default_nettype none

module evtc_parser #(
	parameter int LITERAL_MAX = evtc_pkg::LITERAL_MAX_DEF,
	localparam int CW = $clog2(LITERAL_MAX + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [7:0]     text_char,
	input  wire logic           has_char,
	input  wire logic           end_of_text,
	input  wire logic           count_clr,
	output logic      [CW-1:0]  count,
	output evtc_pkg::act_t      act
);

	import evtc_pkg::*;

	localparam logic [CW-1:0] COUNT_FULL = CW'(LITERAL_MAX);

	phase_t            ph_q, ph_n;
	logic signed [15:0] acc_q, acc_n;
	logic signed [4:0]  max_q, max_n;
	logic [2:0]         err_q, err_n;
	logic [CW-1:0]      count_q, count_new;

	logic signed [8:0]  d;
	logic signed [8:0]  max_ext;
	logic signed [15:0] d16;
	logic signed [15:0] sum3;
	logic               flush_pre;

	assign d       = $signed({1'b0, text_char}) - $signed(9'(CH_ZERO));
	assign d16     = {{7{d[8]}}, d};
	assign max_ext = {{4{max_q[4]}}, max_q};
	assign sum3    = acc_q + d16;
	assign count   = count_q;

	always_comb begin
		ph_n           = ph_q;
		acc_n          = acc_q;
		max_n          = max_q;
		err_n          = err_q;
		flush_pre      = 1'b0;
		act            = '0;
		act.store_byte = text_char;
		act.tok        = TK_NONE;
		if (has_char && ph_q != PH_ERROR) begin
			unique case (ph_q)
				PH_NORMAL: begin
					if (text_char == CH_DOLLAR) begin
						ph_n = PH_DOLLAR;
					end else begin
						act.store = 1'b1;
					end
				end
				PH_DOLLAR: begin
					ph_n = PH_NORMAL;
					if (text_char == CH_DOLLAR) begin
						act.store = 1'b1;
					end else if (text_char == CH_A) begin
						flush_pre = 1'b1;
						acc_n     = '0;
						ph_n      = PH_A1;
					end else if (text_char == CH_T) begin
						flush_pre = 1'b1;
						act.tok   = TK_TIME;
					end else if (text_char >= CH_ONE && text_char <= CH_NINE) begin
						flush_pre    = 1'b1;
						act.tok      = TK_ARG;
						act.arg_byte = text_char - CH_ONE;
						if (d > max_ext) begin
							max_n = d[4:0];
						end
					end else begin
						ph_n  = PH_ERROR;
						err_n = ST_BAD_ESC;
					end
				end
				PH_A1: begin
					acc_n = d16 * 16'sd100;
					ph_n  = PH_A2;
				end
				PH_A2: begin
					acc_n = acc_q + d16 * 16'sd10;
					ph_n  = PH_A3;
				end
				PH_A3: begin
					ph_n = PH_NORMAL;
					if (sum3 > 16'(DEC_LIMIT)) begin
						ph_n  = PH_ERROR;
						err_n = ST_DEC_RANGE;
					end else begin
						act.store      = 1'b1;
						act.store_byte = sum3[7:0];
					end
				end
				default: begin
				end
			endcase
		end

		count_new = count_q + CW'(act.store);

		act.fin        = end_of_text;
		act.fin_byte   = TOK_LIT;
		act.fin_high   = ARG_NONE;
		act.fin_status = ST_OK;
		unique case (ph_n)
			PH_NORMAL: begin
				act.fin_byte = TOK_END;
				act.fin_high = max_n;
			end
			PH_DOLLAR:                 act.fin_status = ST_END_DOLLAR;
			PH_A1, PH_A2, PH_A3:       act.fin_status = ST_END_DEC;
			default:                   act.fin_status = err_n;
		endcase

		act.flush = (act.store && count_new == COUNT_FULL) ||
			(flush_pre && count_q != '0) ||
			(end_of_text && ph_n == PH_NORMAL && count_new != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_NORMAL;
			acc_q   <= '0;
			max_q   <= ARG_NONE;
			err_q   <= ST_OK;
			count_q <= '0;
		end else if (take) begin
			if (end_of_text) begin
				ph_q  <= PH_NORMAL;
				acc_q <= '0;
				max_q <= ARG_NONE;
				err_q <= ST_OK;
				// A run that goes out on this transfer keeps its count until the
				// sequencer has read it; any other run is dropped.
				count_q <= act.flush ? count_new : '0;
			end else begin
				ph_q    <= ph_n;
				acc_q   <= acc_n;
				max_q   <= max_n;
				err_q   <= err_n;
				count_q <= count_new;
			end
		end else if (count_clr) begin
			count_q <= '0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/evtc_seq.sv
`default_nettype none

module evtc_seq #(
	parameter int LITERAL_MAX = evtc_pkg::LITERAL_MAX_DEF,
	localparam int CW = $clog2(LITERAL_MAX + 1),
	localparam int AW = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  evtc_pkg::act_t         act,
	input  wire logic [CW-1:0]     count,
	output logic                   idle,
	output logic                   count_clr,
	output logic                   rd_en,
	output logic      [AW-1:0]     rd_addr,
	input  wire logic [7:0]        rd_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [7:0]        out_byte,
	output logic                   record_end,
	output logic      [2:0]        status,
	output logic signed [4:0]      highest_arg
);

	import evtc_pkg::*;

	localparam logic [2:0] HDR_LAST = 3'd4;
	localparam logic [2:0] HDR_LEN  = 3'd1;

	seq_t               st_q, st_n;
	logic [2:0]         hdr_q, hdr_n;
	logic [CW-1:0]      k_q, k_n, k_inc;
	tok_t               tok_q;
	logic [7:0]         arg_q;
	logic               fin_q;
	logic [7:0]         fin_byte_q;
	logic [2:0]         fin_status_q;
	logic signed [4:0]  fin_high_q;

	logic               out_valid_q;
	logic [7:0]         byte_q;
	logic               end_q;
	logic [2:0]         status_q;
	logic signed [4:0]  high_q;

	logic               slot_free;
	logic               load;
	logic [7:0]         ld_byte;
	logic               ld_end;

	assign slot_free = !out_valid_q || out_ready;
	assign k_inc     = k_q + 1'b1;
	assign idle      = (st_q == SQ_IDLE);

	always_comb begin
		st_n      = st_q;
		hdr_n     = hdr_q;
		k_n       = k_q;
		load      = 1'b0;
		ld_byte   = TOK_LIT;
		ld_end    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		count_clr = 1'b0;
		unique case (st_q)
			SQ_IDLE: begin
				if (take) begin
					st_n  = act.flush ? SQ_HDR : seq_follow(act.tok, act.fin);
					hdr_n = '0;
					k_n   = '0;
				end
			end
			SQ_HDR: begin
				// Keep the first literal in the read register for the data phase.
				rd_en = 1'b1;
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = (hdr_q == HDR_LEN) ? 8'(count) : TOK_LIT;
					if (hdr_q == HDR_LAST) begin
						st_n = SQ_DATA;
					end else begin
						hdr_n = hdr_q + 1'b1;
					end
				end
			end
			SQ_DATA: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = rd_data;
					if (k_inc == count) begin
						count_clr = 1'b1;
						st_n      = seq_follow(tok_q, fin_q);
					end else begin
						k_n     = k_inc;
						rd_en   = 1'b1;
						rd_addr = k_inc[AW-1:0];
					end
				end
			end
			SQ_TOK0: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = (tok_q == TK_TIME) ? TOK_TIME : TOK_ARG;
					if (tok_q == TK_ARG) begin
						st_n = SQ_TOK1;
					end else begin
						st_n = fin_q ? SQ_END : SQ_IDLE;
					end
				end
			end
			SQ_TOK1: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = arg_q;
					st_n    = fin_q ? SQ_END : SQ_IDLE;
				end
			end
			SQ_END: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = fin_byte_q;
					ld_end  = 1'b1;
					st_n    = SQ_IDLE;
				end
			end
			default: begin
				st_n = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= SQ_IDLE;
			hdr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_n;
			hdr_q <= hdr_n;
			k_q   <= k_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q        <= act.tok;
			arg_q        <= act.arg_byte;
			fin_q        <= act.fin;
			fin_byte_q   <= act.fin_byte;
			fin_status_q <= act.fin_status;
			fin_high_q   <= act.fin_high;
		end
		if (load) begin
			byte_q   <= ld_byte;
			end_q    <= ld_end;
			status_q <= ld_end ? fin_status_q : ST_OK;
			high_q   <= ld_end ? fin_high_q : 5'sd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign record_end  = end_q;
	assign status      = status_q;
	assign highest_arg = high_q;

endmodule

`default_nettype wire

>>> hw/rtl/event_template_compiler.sv
// A transfer sets the sequencer state, which then loads the result into the output register.
// Throughput: an item that causes no result is taken every cycle; otherwise the next item is
// taken once the sequencer has placed the item's last result, one result per cycle at most.
// A literal run is a five-byte header, then one literal store read per cycle unless output stalls.
// Reset (arst_n low) clears the parser and sequencer state; the literal store is not cleared.
`default_nettype none

module event_template_compiler #(
	parameter int LITERAL_MAX = evtc_pkg::LITERAL_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        text_char,
	input  wire logic              has_char,
	input  wire logic              end_of_text,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [7:0]        out_byte,
	output logic                   record_end,
	output logic      [2:0]        status,
	output logic signed [4:0]      highest_arg
);

	import evtc_pkg::*;

	localparam int CW = $clog2(LITERAL_MAX + 1);
	localparam int AW = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;

	act_t          act;
	logic          take;
	logic          idle;
	logic          count_clr;
	logic [CW-1:0] count;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign in_ready = idle;
	assign take     = in_valid && idle;

	evtc_parser #(
		.LITERAL_MAX(LITERAL_MAX)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.text_char  (text_char),
		.has_char   (has_char),
		.end_of_text(end_of_text),
		.count_clr  (count_clr),
		.count      (count),
		.act        (act)
	);

	// The literal is written at the current fill position on the transfer itself.
	evtc_ram #(
		.WIDTH(8),
		.DEPTH(LITERAL_MAX)
	) u_store (
		.clk    (clk),
		.wr_en  (take && act.store),
		.wr_addr(count[AW-1:0]),
		.wr_data(act.store_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	evtc_seq #(
		.LITERAL_MAX(LITERAL_MAX)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.act        (act),
		.count      (count),
		.idle       (idle),
		.count_clr  (count_clr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.record_end (record_end),
		.status     (status),
		.highest_arg(highest_arg)
	);

endmodule

`default_nettype wire
